// ----- src/indexed_ordered_list_unit_assert.svh -----
// assertion macros for the indexed ordered list unit
`ifndef INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IOLU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iolu: same-cycle check failed");

`define IOLU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iolu: next-cycle check failed");

`else

`define IOLU_ASSERT_IMP(lbl, ante, cons)

`define IOLU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/iolu_pkg.sv -----
// shared types and constants of the indexed ordered list unit
`default_nettype none

package iolu_pkg;

	localparam int MODE_W      = 3;
	localparam int INDEX_W     = 7;
	localparam int VALUE_IN_W  = 32;
	localparam int STATUS_W    = 2;
	localparam int POS_OUT_W   = 6;
	localparam int COUNT_OUT_W = 7;
	localparam int WINDOW      = 8;

	typedef enum logic [MODE_W-1:0] {
		MD_PUSH_BACK  = 3'd0,
		MD_PUSH_FRONT = 3'd1,
		MD_INSERT     = 3'd2,
		MD_POP_BACK   = 3'd3,
		MD_POP_FRONT  = 3'd4,
		MD_ERASE      = 3'd5,
		MD_CLEAR      = 3'd6,
		MD_FIND       = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE  = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_t;

	typedef struct packed {
		logic open;
		logic close;
		logic find;
		logic shift;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/iolu_req_if.sv -----
// request channel of the indexed ordered list unit
`default_nettype none

interface iolu_req_if;
	import iolu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [INDEX_W-1:0]    index;
	logic [VALUE_IN_W-1:0] value;

	modport source (output valid, mode, index, value, input ready);
	modport sink (input valid, mode, index, value, output ready);
endinterface

`default_nettype wire

// ----- src/iolu_rsp_if.sv -----
// response channel of the indexed ordered list unit
`default_nettype none

interface iolu_rsp_if;
	import iolu_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic                   found;
	logic [POS_OUT_W-1:0]   position;
	logic [COUNT_OUT_W-1:0] count;
	logic                   is_empty;

	modport source (output valid, status, found, position, count, is_empty, input ready);
	modport sink (input valid, status, found, position, count, is_empty, output ready);
endinterface

`default_nettype wire

// ----- src/indexed_ordered_list_unit.sv -----
// top level of the indexed ordered list unit: a row of entry cells
//
//   channel   dir   payload
//   req       in    mode, index, value
//   rsp       out   status, found, position, count, is_empty
//
// push, insert, pop, erase and clear: response valid the cycle after the beat
// find: match flags are captured, then shift through an 8-cell window at the
// head of the row, one window per cycle
// one operation at a time; a response waiting on rsp.ready holds off the next beat
// arst_n empties the list; entry contents are not cleared
`default_nettype none
`include "indexed_ordered_list_unit_assert.svh"

module indexed_ordered_list_unit #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input wire        clk,
	input wire        arst_n,
	iolu_req_if.sink  req,
	iolu_rsp_if.source rsp
);
	import iolu_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int G  = (DEPTH < WINDOW) ? DEPTH : WINDOW;
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

	fsm_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	logic                   out_valid_q;
	status_t                status_q;
	logic                   found_q;
	logic [POS_OUT_W-1:0]   pos_q;
	logic [COUNT_OUT_W-1:0] cnt_out_q;
	logic                   empty_q;

	logic            acc, out_free, load_direct, load_scan, scan_active;
	logic            do_open, do_close, is_find;
	status_t         op_status;
	logic [AW-1:0]   at;
	logic [XW-1:0]   idx_x, cnt_x;
	logic [VALUE_WIDTH-1:0] key;
	cell_cmd_t       cmd;

	logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]       cell_match;

	logic          scan_step, scan_done, scan_found;
	logic [AW-1:0] scan_pos;

	generate
		if (VALUE_WIDTH <= VALUE_IN_W) begin : g_key_narrow
			assign key = req.value[VALUE_WIDTH-1:0];
		end else begin : g_key_wide
			assign key = {{(VALUE_WIDTH - VALUE_IN_W){1'b0}}, req.value};
		end
	endgenerate

	assign acc   = req.valid && req.ready;
	assign idx_x = XW'(req.index);
	assign cnt_x = XW'(cnt_q);

	// operation decode
	always_comb begin
		op_status = STS_DONE;
		do_open   = 1'b0;
		do_close  = 1'b0;
		is_find   = 1'b0;
		at        = '0;
		cnt_d     = cnt_q;
		case (mode_t'(req.mode))
			MD_PUSH_BACK, MD_PUSH_FRONT, MD_INSERT: begin
				if (mode_t'(req.mode) == MD_INSERT && idx_x > cnt_x) begin
					op_status = STS_RANGE;
				end else if (cnt_q == CW'(DEPTH)) begin
					op_status = STS_FULL;
				end else begin
					do_open = 1'b1;
					cnt_d   = cnt_q + CW'(1);
					if (mode_t'(req.mode) == MD_PUSH_BACK) begin
						at = AW'(cnt_q);
					end else if (mode_t'(req.mode) == MD_INSERT) begin
						at = AW'(req.index);
					end
				end
			end
			MD_POP_BACK, MD_POP_FRONT, MD_ERASE: begin
				if (cnt_q == '0) begin
					op_status = STS_EMPTY;
				end else begin
					do_close = 1'b1;
					cnt_d    = cnt_q - CW'(1);
					if (mode_t'(req.mode) == MD_POP_BACK) begin
						at = AW'(cnt_q - CW'(1));
					end else if (mode_t'(req.mode) == MD_ERASE) begin
						at = (idx_x > cnt_x - XW'(1)) ? AW'(cnt_q - CW'(1)) : AW'(req.index);
					end
				end
			end
			MD_CLEAR: begin
				cnt_d = '0;
			end
			MD_FIND: begin
				is_find = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cmd.open  = acc && do_open;
	assign cmd.close = acc && do_close;
	assign cmd.find  = acc && is_find;
	assign cmd.shift = scan_step;

	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_cell
			logic [VALUE_WIDTH-1:0] prev_v, next_v;
			logic                   match_nb;
			if (k == 0) begin : g_head
				assign prev_v = key;
			end else begin : g_mid
				assign prev_v = cell_val[k-1];
			end
			if (k == DEPTH - 1) begin : g_tail
				assign next_v = cell_val[k];
			end else begin : g_body
				assign next_v = cell_val[k+1];
			end
			if (k + G < DEPTH) begin : g_nb
				assign match_nb = cell_match[k+G];
			end else begin : g_nb_end
				assign match_nb = 1'b0;
			end
			iolu_cell #(
				.K  (k),
				.VW (VALUE_WIDTH),
				.AW (AW),
				.CW (CW)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.at       (at),
				.cnt      (cnt_q),
				.key      (key),
				.prev_val (prev_v),
				.next_val (next_v),
				.match_in (match_nb),
				.val      (cell_val[k]),
				.match    (cell_match[k])
			);
		end
	endgenerate

	iolu_scan #(
		.DEPTH (DEPTH),
		.G     (G),
		.CW    (CW),
		.PW    (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.find),
		.active (scan_active),
		.window (cell_match[G-1:0]),
		.cnt    (cnt_q),
		.step   (scan_step),
		.done   (scan_done),
		.found  (scan_found),
		.pos    (scan_pos)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc && is_find) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (scan_done && out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		out_free    = !out_valid_q || rsp.ready;
		req.ready   = (state_q == FSM_IDLE) && out_free;
		scan_active = (state_q == FSM_SCAN);
		load_scan   = scan_active && scan_done && out_free;
		load_direct = acc && !is_find;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				cnt_q <= cnt_d;
			end
			if (load_direct || load_scan) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			status_q  <= op_status;
			found_q   <= 1'b0;
			pos_q     <= '0;
			cnt_out_q <= COUNT_OUT_W'(cnt_d);
			empty_q   <= (cnt_d == '0);
		end else if (load_scan) begin
			status_q  <= STS_DONE;
			found_q   <= scan_found;
			pos_q     <= POS_OUT_W'(scan_pos);
			cnt_out_q <= COUNT_OUT_W'(cnt_q);
			empty_q   <= (cnt_q == '0);
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.found    = found_q;
	assign rsp.position = pos_q;
	assign rsp.count    = cnt_out_q;
	assign rsp.is_empty = empty_q;

	`IOLU_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`IOLU_ASSERT_IMP(a_take_idle, acc, state_q == FSM_IDLE && out_free)
	`IOLU_ASSERT_NXT(a_direct_rsp, load_direct, out_valid_q && state_q == FSM_IDLE)
	`IOLU_ASSERT_IMP(a_scan_quiet, scan_active, !cmd.open && !cmd.close)

endmodule

`default_nettype wire

// ----- src/iolu_cell.sv -----
// one list entry cell with its match flag
`default_nettype none

module iolu_cell #(
	parameter int K  = 0,
	parameter int VW = 32,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  wire                 clk,
	input  iolu_pkg::cell_cmd_t cmd,
	input  wire  [AW-1:0]       at,
	input  wire  [CW-1:0]       cnt,
	input  wire  [VW-1:0]       key,
	input  wire  [VW-1:0]       prev_val,
	input  wire  [VW-1:0]       next_val,
	input  wire                 match_in,
	output logic [VW-1:0]       val,
	output logic                match
);
	import iolu_pkg::*;

	localparam logic [AW-1:0] K_AT  = AW'(K);
	localparam logic [CW-1:0] K_CNT = CW'(K);

	logic [VW-1:0] val_q;
	logic          match_q;

	always_ff @(posedge clk) begin
		if (cmd.open) begin
			if (K_AT == at) begin
				val_q <= key;
			end else if (K_AT > at) begin
				val_q <= prev_val;
			end
		end else if (cmd.close) begin
			if (K_AT >= at) begin
				val_q <= next_val;
			end
		end
	end

	// flags hop one window toward the head on each scan step
	always_ff @(posedge clk) begin
		if (cmd.find) begin
			match_q <= (K_CNT < cnt) && (val_q == key);
		end else if (cmd.shift) begin
			match_q <= match_in;
		end
	end

	assign val   = val_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ----- src/iolu_scan.sv -----
// window scan that locates the first matching entry
`default_nettype none

module iolu_scan #(
	parameter int DEPTH = 64,
	parameter int G     = 8,
	parameter int CW    = 7,
	parameter int PW    = 6
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire           active,
	input  wire  [G-1:0]  window,
	input  wire  [CW-1:0] cnt,
	output logic          step,
	output logic          done,
	output logic          found,
	output logic [PW-1:0] pos
);
	import iolu_pkg::*;

	localparam int NG = (DEPTH + G - 1) / G;
	localparam int GW = $clog2(NG + 1);
	localparam int OW = $clog2(G);
	localparam int SW = $clog2(DEPTH + G + 1);

	logic [GW-1:0] grp_q;
	logic [OW-1:0] off;
	logic [SW-1:0] covered;
	logic [SW-1:0] base;

	always_comb begin
		off = '0;
		for (int i = G - 1; i >= 0; i--) begin
			if (window[i]) begin
				off = OW'(i);
			end
		end
	end

	assign base    = SW'(grp_q) * SW'(G);
	assign covered = base + SW'(G);
	assign found   = |window;
	assign done    = found || (covered >= SW'(cnt));
	assign step    = active && !done;
	assign pos     = found ? PW'(base + SW'(off)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (start) begin
			grp_q <= '0;
		end else if (step) begin
			grp_q <= grp_q + GW'(1);
		end
	end

endmodule

`default_nettype wire
